FILE: sv/rvcd_pkg.sv
package rvcd_pkg;

  // major opcodes
  localparam logic [6:0] OPC_R      = 7'b0110011;
  localparam logic [6:0] OPC_IARITH = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_EXIT   = 7'b1111111;
  localparam logic [6:0] OPC_NOP    = 7'b0000000;

  // funct7 values
  localparam logic [6:0] F7_ALT  = 7'b0100000;
  localparam logic [6:0] F7_BASE = 7'b0000000;

  // funct3 codes that need a second look
  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SR  = 3'd5;

  // instruction kind codes
  localparam logic [5:0] KIND_UNDEF = 6'd0;
  localparam logic [5:0] KIND_ADD   = 6'd1;
  localparam logic [5:0] KIND_SUB   = 6'd2;
  localparam logic [5:0] KIND_SLL   = 6'd3;
  localparam logic [5:0] KIND_SLT   = 6'd4;
  localparam logic [5:0] KIND_SLTU  = 6'd5;
  localparam logic [5:0] KIND_XOR   = 6'd6;
  localparam logic [5:0] KIND_SRL   = 6'd7;
  localparam logic [5:0] KIND_SRA   = 6'd8;
  localparam logic [5:0] KIND_OR    = 6'd9;
  localparam logic [5:0] KIND_AND   = 6'd10;
  localparam logic [5:0] KIND_ADDI  = 6'd11;
  localparam logic [5:0] KIND_SLLI  = 6'd12;
  localparam logic [5:0] KIND_SLTI  = 6'd13;
  localparam logic [5:0] KIND_SLTIU = 6'd14;
  localparam logic [5:0] KIND_XORI  = 6'd15;
  localparam logic [5:0] KIND_SRLI  = 6'd16;
  localparam logic [5:0] KIND_SRAI  = 6'd17;
  localparam logic [5:0] KIND_ORI   = 6'd18;
  localparam logic [5:0] KIND_ANDI  = 6'd19;
  localparam logic [5:0] KIND_LB    = 6'd20;
  localparam logic [5:0] KIND_LH    = 6'd21;
  localparam logic [5:0] KIND_LW    = 6'd22;
  localparam logic [5:0] KIND_LBU   = 6'd23;
  localparam logic [5:0] KIND_LHU   = 6'd24;
  localparam logic [5:0] KIND_SB    = 6'd25;
  localparam logic [5:0] KIND_SH    = 6'd26;
  localparam logic [5:0] KIND_SW    = 6'd27;
  localparam logic [5:0] KIND_BEQ   = 6'd28;
  localparam logic [5:0] KIND_BNE   = 6'd29;
  localparam logic [5:0] KIND_BLT   = 6'd30;
  localparam logic [5:0] KIND_BGE   = 6'd31;
  localparam logic [5:0] KIND_BLTU  = 6'd32;
  localparam logic [5:0] KIND_BGEU  = 6'd33;
  localparam logic [5:0] KIND_JAL   = 6'd34;
  localparam logic [5:0] KIND_JALR  = 6'd35;
  localparam logic [5:0] KIND_LUI   = 6'd36;
  localparam logic [5:0] KIND_AUIPC = 6'd37;
  localparam logic [5:0] KIND_NOP   = 6'd38;
  localparam logic [5:0] KIND_EXIT  = 6'd39;

  // access sizes in bytes
  localparam logic [2:0] BYTES_NONE = 3'd0;
  localparam logic [2:0] BYTES_1    = 3'd1;
  localparam logic [2:0] BYTES_2    = 3'd2;
  localparam logic [2:0] BYTES_4    = 3'd4;

  typedef enum logic [3:0] {
    ALU_ADD     = 4'd0,
    ALU_SUB     = 4'd1,
    ALU_XOR     = 4'd2,
    ALU_OR      = 4'd3,
    ALU_AND     = 4'd4,
    ALU_SLL     = 4'd5,
    ALU_SRL     = 4'd6,
    ALU_SRA     = 4'd7,
    ALU_SLT     = 4'd8,
    ALU_SLTU    = 4'd9,
    ALU_COMPARE = 4'd10,
    ALU_NONE    = 4'd11
  } alu_op_t;

  typedef enum logic [2:0] {
    BR_NONE   = 3'd0,
    BR_EQ     = 3'd1,
    BR_NE     = 3'd2,
    BR_LT     = 3'd3,
    BR_GE     = 3'd4,
    BR_LTU    = 3'd5,
    BR_GEU    = 3'd6,
    BR_ALWAYS = 3'd7
  } br_cond_t;

  typedef enum logic [1:0] {
    WB_ALU  = 2'd0,
    WB_LOAD = 2'd1,
    WB_PC4  = 2'd2
  } wb_src_t;

  typedef struct packed {
    logic [5:0] inst_kind;
    logic       uses_immediate;
    logic       is_auipc;
    logic       jump_register_select;
    alu_op_t    alu_op;
    br_cond_t   branch_cond;
    logic       is_load;
    logic       is_store;
    logic [2:0] access_bytes;
    logic       writes_register;
    wb_src_t    wb_source;
    logic       is_exit;
  } dec_t;

  // alu operation for register and immediate arithmetic
  function automatic alu_op_t arith_alu(input logic [2:0] f3, input logic [6:0] f7,
                                        input logic is_reg);
    alu_op_t op;
    unique case (f3)
      3'd0: begin
        if (!is_reg || f7 == F7_BASE) op = ALU_ADD;
        else if (f7 == F7_ALT)        op = ALU_SUB;
        else                          op = ALU_NONE;
      end
      3'd1: op = ALU_SLL;
      3'd2: op = ALU_SLT;
      3'd3: op = ALU_SLTU;
      3'd4: op = ALU_XOR;
      3'd5: begin
        if (f7 == F7_BASE)     op = ALU_SRL;
        else if (f7 == F7_ALT) op = ALU_SRA;
        else                   op = ALU_NONE;
      end
      3'd6: op = ALU_OR;
      3'd7: op = ALU_AND;
      default: op = ALU_NONE;
    endcase
    return op;
  endfunction

  // kind code for register and immediate arithmetic
  function automatic logic [5:0] arith_kind(input logic [2:0] f3, input logic [6:0] f7,
                                            input logic is_reg);
    logic [5:0] k;
    unique case (f3)
      3'd0: begin
        if (!is_reg)           k = KIND_ADDI;
        else if (f7 == F7_BASE) k = KIND_ADD;
        else if (f7 == F7_ALT)  k = KIND_SUB;
        else                    k = KIND_UNDEF;
      end
      3'd1: k = is_reg ? KIND_SLL : KIND_SLLI;
      3'd2: k = is_reg ? KIND_SLT : KIND_SLTI;
      3'd3: k = is_reg ? KIND_SLTU : KIND_SLTIU;
      3'd4: k = is_reg ? KIND_XOR : KIND_XORI;
      3'd5: begin
        if (f7 == F7_BASE)     k = is_reg ? KIND_SRL : KIND_SRLI;
        else if (f7 == F7_ALT) k = is_reg ? KIND_SRA : KIND_SRAI;
        else                   k = KIND_UNDEF;
      end
      3'd6: k = is_reg ? KIND_OR : KIND_ORI;
      3'd7: k = is_reg ? KIND_AND : KIND_ANDI;
      default: k = KIND_UNDEF;
    endcase
    return k;
  endfunction

endpackage

FILE: sv/rv32i_control_decoder.sv
// an accepted input beat reaches its result beat through the input register, then
// the decode logic and then the result register
// throughput: one beat per cycle, sustained while the result side does not stall
// stall on the input side follows a full input register behind a full result register that is being held
// reset clears only the two valid flags; the payload registers are not reset
module rv32i_control_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] instruction_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  inst_kind,
  output logic        uses_immediate,
  output logic        is_auipc,
  output logic        jump_register_select,
  output logic [3:0]  alu_op,
  output logic [2:0]  branch_cond,
  output logic        is_load,
  output logic        is_store,
  output logic [2:0]  access_bytes,
  output logic        writes_register,
  output logic [1:0]  wb_source,
  output logic        is_exit
);
  import rvcd_pkg::*;

  logic        stage_valid;
  logic [31:0] stage_word;
  dec_t        result;
  dec_t        dec;
  logic        out_free;
  logic        stage_free;

  // pipeline advance conditions
  assign out_free   = !out_valid || !out_stall;
  assign stage_free = !stage_valid || out_free;
  assign in_stall   = !stage_free;

  rvcd_decode u_decode (
    .instruction_word (stage_word),
    .dec              (dec)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (stage_free) stage_valid <= in_valid;
      if (out_free)   out_valid   <= stage_valid;
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (in_valid && stage_free) begin
      stage_word <= instruction_word;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (stage_valid && out_free) begin
      result <= dec;
    end
  end

  // result fields
  assign inst_kind            = result.inst_kind;
  assign uses_immediate       = result.uses_immediate;
  assign is_auipc             = result.is_auipc;
  assign jump_register_select = result.jump_register_select;
  assign alu_op               = result.alu_op;
  assign branch_cond          = result.branch_cond;
  assign is_load              = result.is_load;
  assign is_store             = result.is_store;
  assign access_bytes         = result.access_bytes;
  assign writes_register      = result.writes_register;
  assign wb_source            = result.wb_source;
  assign is_exit              = result.is_exit;

endmodule

FILE: sv/rvcd_decode.sv
module rvcd_decode (
  input  logic [31:0]   instruction_word,
  output rvcd_pkg::dec_t dec
);
  import rvcd_pkg::*;

  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;

  assign opc = instruction_word[6:0];
  assign f3  = instruction_word[14:12];
  assign f7  = instruction_word[31:25];

  // field decode from opcode, funct3 and funct7
  always_comb begin
    dec                      = '0;
    dec.inst_kind            = KIND_UNDEF;
    dec.alu_op               = ALU_NONE;
    dec.branch_cond          = BR_NONE;
    dec.access_bytes         = BYTES_NONE;
    dec.wb_source            = WB_ALU;
    unique case (opc)
      OPC_R: begin
        dec.inst_kind       = arith_kind(f3, f7, 1'b1);
        dec.alu_op          = arith_alu(f3, f7, 1'b1);
        dec.writes_register = 1'b1;
      end
      OPC_IARITH: begin
        dec.inst_kind       = arith_kind(f3, f7, 1'b0);
        dec.alu_op          = arith_alu(f3, f7, 1'b0);
        dec.uses_immediate  = 1'b1;
        dec.writes_register = 1'b1;
      end
      OPC_LOAD: begin
        unique case (f3)
          3'd0: begin dec.inst_kind = KIND_LB;  dec.access_bytes = BYTES_1; end
          3'd1: begin dec.inst_kind = KIND_LH;  dec.access_bytes = BYTES_2; end
          3'd2: begin dec.inst_kind = KIND_LW;  dec.access_bytes = BYTES_4; end
          3'd4: begin dec.inst_kind = KIND_LBU; dec.access_bytes = BYTES_1; end
          3'd5: begin dec.inst_kind = KIND_LHU; dec.access_bytes = BYTES_2; end
          default: begin
            dec.inst_kind    = KIND_UNDEF;
            dec.access_bytes = BYTES_NONE;
          end
        endcase
        dec.alu_op          = ALU_ADD;
        dec.uses_immediate  = 1'b1;
        dec.is_load         = 1'b1;
        dec.writes_register = 1'b1;
        dec.wb_source       = WB_LOAD;
      end
      OPC_STORE: begin
        unique case (f3)
          3'd0: begin dec.inst_kind = KIND_SB; dec.access_bytes = BYTES_1; end
          3'd1: begin dec.inst_kind = KIND_SH; dec.access_bytes = BYTES_2; end
          3'd2: begin dec.inst_kind = KIND_SW; dec.access_bytes = BYTES_4; end
          default: begin
            dec.inst_kind    = KIND_UNDEF;
            dec.access_bytes = BYTES_NONE;
          end
        endcase
        dec.alu_op         = ALU_ADD;
        dec.uses_immediate = 1'b1;
        dec.is_store       = 1'b1;
      end
      OPC_BRANCH: begin
        unique case (f3)
          3'd0: begin dec.inst_kind = KIND_BEQ;  dec.branch_cond = BR_EQ;  end
          3'd1: begin dec.inst_kind = KIND_BNE;  dec.branch_cond = BR_NE;  end
          3'd4: begin dec.inst_kind = KIND_BLT;  dec.branch_cond = BR_LT;  end
          3'd5: begin dec.inst_kind = KIND_BGE;  dec.branch_cond = BR_GE;  end
          3'd6: begin dec.inst_kind = KIND_BLTU; dec.branch_cond = BR_LTU; end
          3'd7: begin dec.inst_kind = KIND_BGEU; dec.branch_cond = BR_GEU; end
          default: begin
            dec.inst_kind   = KIND_UNDEF;
            dec.branch_cond = BR_NONE;
          end
        endcase
        dec.alu_op = ALU_COMPARE;
      end
      OPC_JAL: begin
        dec.inst_kind       = KIND_JAL;
        dec.branch_cond     = BR_ALWAYS;
        dec.writes_register = 1'b1;
        dec.wb_source       = WB_PC4;
      end
      OPC_JALR: begin
        dec.inst_kind            = KIND_JALR;
        dec.branch_cond          = BR_ALWAYS;
        dec.alu_op               = ALU_ADD;
        dec.uses_immediate       = 1'b1;
        dec.jump_register_select = 1'b1;
        dec.writes_register      = 1'b1;
        dec.wb_source            = WB_PC4;
      end
      OPC_LUI: begin
        dec.inst_kind       = KIND_LUI;
        dec.uses_immediate  = 1'b1;
        dec.writes_register = 1'b1;
      end
      OPC_AUIPC: begin
        dec.inst_kind       = KIND_AUIPC;
        dec.uses_immediate  = 1'b1;
        dec.is_auipc        = 1'b1;
        dec.writes_register = 1'b1;
      end
      OPC_NOP: begin
        dec.inst_kind = KIND_NOP;
      end
      OPC_EXIT: begin
        dec.inst_kind = KIND_EXIT;
        dec.is_exit   = 1'b1;
      end
      default: begin
        dec.inst_kind = KIND_UNDEF;
      end
    endcase
  end

endmodule
